FILE: rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/i2ccrc_pkg.sv
// package: types, codes and crc-8 helpers for the i2c register crc framer
package i2ccrc_pkg;

    localparam logic [7:0] CRC_POLY       = 8'h07;
    localparam logic [7:0] CRC_INIT       = 8'h00;
    localparam logic [7:0] CRC_TOP        = 8'h80;
    localparam logic [7:0] DEV_ADDR_RESET = 8'h10;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_DROPPED  = 2'd2
    } status_t;

    // crc of a single set input bit after eight shifts, msb first
    typedef logic [7:0] crc_col_t [8];
    localparam crc_col_t CRC_COLUMNS = '{
        8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC7, 8'h89
    };

    // one byte of crc-8: linear in (crc ^ b), so an xor of columns
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = crc ^ b;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (x[i])
            begin
                acc = acc ^ CRC_COLUMNS[i];
            end
        end
        return acc;
    endfunction

endpackage

FILE: rtl/i2c_register_crc_framer.sv
// top level: crc-8 i2c register link framer, one transaction per cycle unless stalled
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------------
//  config   | cfg_wr_en               | cfg_wr_data (device_address)
//  input    | in_valid / in_ready     | req_type reg_addr data_byte crc_byte first/last
//  output   | out_valid / out_ready   | data_out crc_out status burst_done burst_good
//
// one transaction is taken per cycle unless the output stalls; a result becomes valid
// once its input transaction has passed through the input register, then the result
// register
// the crc over up to three bytes is a flat xor network between the two registers
// rst_n clears the valid flags and the burst state and loads address 0x10
// a stall on the output holds the result register, then backs up the input register
module i2c_register_crc_framer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 req_type,
    input  logic [7:0]           reg_addr,
    input  logic [7:0]           data_byte,
    input  logic [7:0]           crc_byte,
    input  logic                 first_of_read,
    input  logic                 last_of_read,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           data_out,
    output logic [7:0]           crc_out,
    output i2ccrc_pkg::status_t  status,
    output logic                 burst_done,
    output logic                 burst_good
);
    import i2ccrc_pkg::*;

    // configuration
    logic [7:0] dev_addr_reg;

    // input register
    logic       s1_valid_reg;
    logic       s1_req_reg;
    logic [7:0] s1_reg_addr_reg;
    logic [7:0] s1_data_reg;
    logic [7:0] s1_crc_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] data_out_reg;
    logic [7:0] crc_out_reg;
    status_t    status_reg;
    logic       done_reg;
    logic       good_reg;

    // burst state, updated as a transaction moves into the result register
    logic       burst_failed_reg;
    logic       burst_failed_next;

    logic       s1_advance;
    logic [7:0] read_addr;
    logic [7:0] crc_write;
    logic [7:0] crc_first;
    logic [7:0] crc_later;
    logic [7:0] data_out_next;
    logic [7:0] crc_out_next;
    status_t    status_next;
    logic       done_next;
    logic       good_next;

    // the input register moves on when the result register is empty or draining
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // read address wraps to 8 bits
    assign read_addr = dev_addr_reg + 8'd1;

    // write crc covers device address, register address and data byte
    assign crc_write = crc8_step(crc8_step(crc8_step(CRC_INIT, dev_addr_reg),
                                           s1_reg_addr_reg), s1_data_reg);
    // first read pair also covers the read address
    assign crc_first = crc8_step(crc8_step(CRC_INIT, read_addr), s1_data_reg);
    assign crc_later = crc8_step(CRC_INIT, s1_data_reg);

    always_comb
    begin
        data_out_next     = '0;
        crc_out_next      = crc_write;
        status_next       = STATUS_GOOD;
        done_next         = 1'b0;
        good_next         = 1'b0;
        burst_failed_next = burst_failed_reg;
        if (s1_req_reg == REQ_WRITE)
        begin
            data_out_next = s1_data_reg;
        end
        else
        begin
            // a first pair opens a fresh burst
            if (s1_first_reg)
            begin
                burst_failed_next = 1'b0;
                crc_out_next      = crc_first;
            end
            else
            begin
                crc_out_next = crc_later;
            end
            if (burst_failed_next)
            begin
                status_next = STATUS_DROPPED;
            end
            else if (crc_out_next != s1_crc_reg)
            begin
                status_next       = STATUS_MISMATCH;
                burst_failed_next = 1'b1;
            end
            else
            begin
                data_out_next = s1_data_reg;
            end
            // last pair reports the burst verdict and closes it
            if (s1_last_reg)
            begin
                done_next         = 1'b1;
                good_next         = !burst_failed_next;
                burst_failed_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg     <= DEV_ADDR_RESET;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            burst_failed_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dev_addr_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg    <= 1'b1;
                burst_failed_reg <= burst_failed_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg      <= req_type;
            s1_reg_addr_reg <= reg_addr;
            s1_data_reg     <= data_byte;
            s1_crc_reg      <= crc_byte;
            s1_first_reg    <= first_of_read;
            s1_last_reg     <= last_of_read;
        end
        if (s1_advance)
        begin
            data_out_reg <= data_out_next;
            crc_out_reg  <= crc_out_next;
            status_reg   <= status_next;
            done_reg     <= done_next;
            good_reg     <= good_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = data_out_reg;
    assign crc_out    = crc_out_reg;
    assign status     = status_reg;
    assign burst_done = done_reg;
    assign burst_good = good_reg;

endmodule

FILE: rtl/i2ccrc_checker.sv
// checker: port-level assertions for the i2c register crc framer, with bind
`include "assert_macros.svh"

module i2ccrc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [7:0]           data_out,
    input logic [7:0]           crc_out,
    input i2ccrc_pkg::status_t  status,
    input logic                 burst_done,
    input logic                 burst_good
);
    import i2ccrc_pkg::*;

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(data_out) && $stable(crc_out) && $stable(status), "stalled result changed")

    // rejected or dropped byte never reaches the buffer
    `ASSERT_IMPLIES(a_reject_zero, clk, rst_n, out_valid && (status != STATUS_GOOD), data_out == 8'd0, "rejected byte passed on")

    // verdict only comes with the end of a burst
    `ASSERT_IMPLIES(a_good_done, clk, rst_n, out_valid && burst_good, burst_done, "burst_good without burst_done")

    // a failing last pair cannot report a good burst
    `ASSERT_IMPLIES(a_fail_verdict, clk, rst_n, out_valid && burst_done && (status != STATUS_GOOD), !burst_good, "bad last pair reported good")

    // status code stays in range
    `ASSERT_ALWAYS(a_status_range, clk, rst_n, !out_valid || (status == STATUS_GOOD) || (status == STATUS_MISMATCH) || (status == STATUS_DROPPED), "status out of range")

endmodule

bind i2c_register_crc_framer i2ccrc_checker u_i2ccrc_checker (.*);
